### rtl/sbfr_pkg.sv
// ----------------------------------------------------------------------------
// sbfr_pkg
// Shared types, codes and number-parsing helpers of the sized and braced
// frame receiver.
// ----------------------------------------------------------------------------
package sbfr_pkg;

    localparam int SBFR_BUFFER_DEPTH  = 256;
    localparam int SBFR_MAX_BRACE_LEN = 64;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_SIZED  = 3'd1,
        ST_BRACE  = 3'd2,
        ST_HEADER = 3'd3,
        ST_READY  = 3'd4
    } t_rx_state;

    typedef enum logic [1:0] {
        FN_BYTE = 2'd0,
        FN_DONE = 2'd1,
        FN_READ = 2'd2,
        FN_NOP  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_BRACE = 2'd1,
        KIND_SIZED = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_DONE   = 2'd2
    } t_phase;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // Number being accumulated, together with its parse phase and sign.
    typedef struct packed {
        logic [7:0] value;
        t_phase     phase;
        logic       negative;
    } t_num;

    // Status of one transaction, captured at acceptance.
    typedef struct packed {
        t_rx_state  state;
        logic       dropped;
        logic [7:0] length;
        logic [7:0] size;
        logic [7:0] id;
        t_kind      kind;
        logic       ready;
    } t_result;

    // Finish a number: apply the sign if digits were being taken.
    function automatic t_num close_num(t_num n);
        t_num r;
        r = n;
        if (n.phase == PH_DIGITS && n.negative) begin
            r.value = 8'd0 - n.value;
        end
        r.phase = PH_DONE;
        return r;
    endfunction

    // Advance a number by one character, modulo 256.
    function automatic t_num feed_num(t_num n, logic [7:0] b);
        t_num       r;
        logic       digit;
        logic [7:0] dval;
        r     = n;
        digit = (b >= CH_ZERO) && (b <= CH_NINE);
        dval  = b - CH_ZERO;
        case (n.phase)
            PH_SKIP: begin
                if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)) begin
                    r = n;
                end else if (b == CH_PLUS || b == CH_MINUS) begin
                    r.negative = (b == CH_MINUS);
                    r.phase    = PH_DIGITS;
                end else if (digit) begin
                    r.value = dval;
                    r.phase = PH_DIGITS;
                end else begin
                    r.phase = PH_DONE;
                end
            end
            PH_DIGITS: begin
                if (digit) begin
                    r.value = (n.value << 3) + (n.value << 1) + dval;
                end else begin
                    r = close_num(n);
                end
            end
            default: begin
                r = n;
            end
        endcase
        return r;
    endfunction

endpackage

### rtl/sized_and_braced_frame_receiver.sv
// ----------------------------------------------------------------------------
// sized_and_braced_frame_receiver
// Frame receiver for a character stream: brace frames "{...}" and sized
// frames "<id, size>" followed by size data bytes, stored for read-back.
// ----------------------------------------------------------------------------
//
//  channel  dir  tdata                                   tuser
//  -------  ---  --------------------------------------  ------------------
//  s_axis   in   rx_byte, read_index                     func
//  m_axis   out  msg_ready, conn_id, data_size,          frame_kind
//                msg_length, read_byte, frame_dropped,
//                receiver_state
//
//  Every transaction yields exactly one result transaction. The block takes
//  one transaction per cycle while the output is not stalled; a result passes
//  through the middle stage, which waits on the registered read of the
//  buffer RAM, and then through the output register.
//  Synchronous active-low reset clears all control state; the buffer needs
//  no clearing pass, since a valid bit per entry makes a never-written
//  entry read as zero.
//  A stalled output holds its result; the input keeps flowing as long as the
//  middle stage can advance.
//
//  The buffer is split into an even and an odd bank, so a stored byte and
//  the zero terminator after it (always at consecutive positions) land in
//  different banks in the same cycle.
// ----------------------------------------------------------------------------
module sized_and_braced_frame_receiver
    import sbfr_pkg::*;
#(
    parameter int BUFFER_DEPTH  = SBFR_BUFFER_DEPTH,
    parameter int MAX_BRACE_LEN = SBFR_MAX_BRACE_LEN
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] rx_byte, [15:8] read_index
    input  logic [1:0]  s_axis_tuser,   // [1:0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [0] msg_ready, [8:1] conn_id,
                                        // [16:9] data_size, [24:17] msg_length,
                                        // [32:25] read_byte, [33] frame_dropped,
                                        // [36:34] receiver_state, [39:37] zero
    output logic [1:0]  m_axis_tuser    // [1:0] frame_kind
);

    // Brace frames are limited by the brace limit and by the room kept for
    // the terminator.
    localparam int BRACE_LIM = (MAX_BRACE_LEN < BUFFER_DEPTH) ? MAX_BRACE_LEN
                                                             : BUFFER_DEPTH - 1;
    localparam logic [7:0] BRACE_LIM8 = 8'(BRACE_LIM);
    localparam logic [7:0] BUF_LAST8  = 8'(BUFFER_DEPTH - 1);
    localparam int HALF = (BUFFER_DEPTH + 1) / 2;
    localparam int AW   = $clog2(HALF);
    localparam int VW   = $clog2(BUFFER_DEPTH);

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    t_rx_state          r_state, n_state;
    logic [7:0]         r_wp, n_wp;
    logic [7:0]         r_id, n_id;
    logic [7:0]         r_size, n_size;
    t_phase             r_phase, n_phase;
    logic               r_neg, n_neg;
    logic               r_after_comma, n_after_comma;
    logic [7:0]         r_len, n_len;
    t_kind              r_kind, n_kind;
    logic [BUFFER_DEPTH-1:0] r_vld, n_vld;

    // Pipeline: middle stage (waits on RAM read data) and output register.
    logic               r_s1_vld;
    logic               r_s1_rd;
    logic               r_s1_bank;
    t_result            r_s1_res;
    logic               r_out_vld;
    logic [39:0]        r_out_data;
    logic [1:0]         r_out_user;

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    logic       in_fire;
    t_func      in_func;
    logic [7:0] in_byte;
    logic [7:0] in_idx;
    logic       out_free;
    logic       s1_move;

    assign out_free      = !r_out_vld || m_axis_tready;
    assign s1_move       = r_s1_vld && out_free;
    assign s_axis_tready = !r_s1_vld || out_free;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_func       = t_func'(s_axis_tuser);
    assign in_byte       = s_axis_tdata[7:0];
    assign in_idx        = s_axis_tdata[15:8];

    logic       take_byte;
    logic [7:0] wp1;
    logic       brace_full;
    logic       buf_full;
    t_num       id_num;
    t_num       size_num;
    t_num       id_closed;
    t_num       size_closed;
    t_num       id_fed;
    t_num       size_fed;
    logic [7:0] hdr_size;
    logic       hdr_zero;
    logic       sized_done;

    assign take_byte   = in_fire && (in_func == FN_BYTE);
    assign wp1         = r_wp + 8'd1;
    assign brace_full  = r_wp >= BRACE_LIM8;
    assign buf_full    = r_wp >= BUF_LAST8;
    assign id_num      = '{value: r_id, phase: r_phase, negative: r_neg};
    assign size_num    = '{value: r_size, phase: r_phase, negative: r_neg};
    assign id_closed   = close_num(id_num);
    assign size_closed = close_num(size_num);
    assign id_fed      = feed_num(id_num, in_byte);
    assign size_fed    = feed_num(size_num, in_byte);
    // A header without a comma closes with size zero.
    assign hdr_size    = r_after_comma ? size_closed.value : 8'd0;
    assign hdr_zero    = (hdr_size == 8'd0);
    assign sized_done  = wp1 >= r_size;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        if (in_fire) begin
            case (in_func)
                FN_BYTE: begin
                    case (r_state)
                        ST_IDLE: begin
                            if (in_byte == CH_LBRACE) begin
                                n_state = ST_BRACE;
                            end else if (in_byte == CH_LT) begin
                                n_state = ST_HEADER;
                            end
                        end
                        ST_BRACE: begin
                            if (brace_full) begin
                                n_state = ST_IDLE;
                            end else if (in_byte == CH_RBRACE) begin
                                n_state = ST_READY;
                            end
                        end
                        ST_HEADER: begin
                            if (buf_full) begin
                                n_state = ST_IDLE;
                            end else if (in_byte == CH_GT) begin
                                n_state = hdr_zero ? ST_READY : ST_SIZED;
                            end
                        end
                        ST_SIZED: begin
                            if (buf_full) begin
                                n_state = ST_IDLE;
                            end else if (sized_done) begin
                                n_state = ST_READY;
                            end
                        end
                        default: begin
                            n_state = r_state;
                        end
                    endcase
                end
                FN_DONE: begin
                    n_state = ST_IDLE;
                end
                default: begin
                    n_state = r_state;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Datapath: counters, parsed numbers, buffer writes
    // ------------------------------------------------------------------
    logic       we_main;
    logic       we_term;
    logic [7:0] main_addr;
    logic       dropped;

    always_comb begin
        n_wp          = r_wp;
        n_id          = r_id;
        n_size        = r_size;
        n_phase       = r_phase;
        n_neg         = r_neg;
        n_after_comma = r_after_comma;
        n_len         = r_len;
        n_kind        = r_kind;
        we_main       = 1'b0;
        we_term       = 1'b0;
        main_addr     = r_wp;
        dropped       = 1'b0;
        if (take_byte) begin
            case (r_state)
                ST_IDLE: begin
                    n_wp      = 8'd0;
                    main_addr = 8'd0;
                    if (in_byte == CH_LBRACE || in_byte == CH_LT) begin
                        we_main = 1'b1;
                        n_wp    = 8'd1;
                        n_kind  = KIND_NONE;
                        n_len   = 8'd0;
                    end
                    if (in_byte == CH_LT) begin
                        n_id          = 8'd0;
                        n_size        = 8'd0;
                        n_phase       = PH_SKIP;
                        n_neg         = 1'b0;
                        n_after_comma = 1'b0;
                    end
                end
                ST_BRACE: begin
                    if (brace_full) begin
                        dropped = 1'b1;
                        n_wp    = 8'd0;
                    end else begin
                        we_main = 1'b1;
                        if (in_byte == CH_RBRACE) begin
                            we_term = 1'b1;
                            n_len   = wp1;
                            n_kind  = KIND_BRACE;
                            n_wp    = 8'd0;
                        end else begin
                            n_wp = wp1;
                        end
                    end
                end
                ST_HEADER: begin
                    if (buf_full) begin
                        dropped = 1'b1;
                        n_wp    = 8'd0;
                    end else begin
                        we_main = 1'b1;
                        n_wp    = wp1;
                        if (in_byte == CH_GT) begin
                            // Terminator follows the header in both cases.
                            we_term = 1'b1;
                            n_wp    = 8'd0;
                            n_phase = PH_DONE;
                            n_size  = hdr_size;
                            if (!r_after_comma) begin
                                n_id = id_closed.value;
                            end
                            if (hdr_zero) begin
                                n_len  = wp1;
                                n_kind = KIND_SIZED;
                            end
                        end else if (!r_after_comma) begin
                            if (in_byte == CH_COMMA) begin
                                n_id          = id_closed.value;
                                n_after_comma = 1'b1;
                                n_phase       = PH_SKIP;
                                n_neg         = 1'b0;
                            end else begin
                                n_id    = id_fed.value;
                                n_phase = id_fed.phase;
                                n_neg   = id_fed.negative;
                            end
                        end else begin
                            n_size  = size_fed.value;
                            n_phase = size_fed.phase;
                            n_neg   = size_fed.negative;
                        end
                    end
                end
                ST_SIZED: begin
                    if (buf_full) begin
                        dropped = 1'b1;
                        n_wp    = 8'd0;
                    end else begin
                        we_main = 1'b1;
                        if (sized_done) begin
                            we_term = 1'b1;
                            n_len   = wp1;
                            n_kind  = KIND_SIZED;
                            n_wp    = 8'd0;
                        end else begin
                            n_wp = wp1;
                        end
                    end
                end
                default: begin
                    n_wp = r_wp;
                end
            endcase
        end else if (in_fire && in_func == FN_DONE) begin
            n_wp          = 8'd0;
            n_phase       = PH_SKIP;
            n_neg         = 1'b0;
            n_after_comma = 1'b0;
            n_kind        = KIND_NONE;
            n_len         = 8'd0;
        end
    end

    // ------------------------------------------------------------------
    // Bank write steering: the terminator always sits one above the byte.
    // ------------------------------------------------------------------
    logic [7:0] term_addr;
    logic       main_ok;
    logic       term_ok;
    logic [6:0] main_half;
    logic [6:0] term_half;
    logic [1:0] bank_we;
    logic [AW-1:0] bank_waddr [2];
    logic [7:0]    bank_wdata [2];

    assign term_addr = main_addr + 8'd1;
    assign main_ok   = we_main && (main_addr <= BUF_LAST8);
    assign term_ok   = we_term && (term_addr <= BUF_LAST8);
    assign main_half = main_addr[7:1];
    assign term_half = term_addr[7:1];

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            if (main_ok && main_addr[0] == 1'(k)) begin
                bank_we[k]    = 1'b1;
                bank_waddr[k] = main_half[AW-1:0];
                bank_wdata[k] = in_byte;
            end else begin
                bank_we[k]    = term_ok && (term_addr[0] == 1'(k));
                bank_waddr[k] = term_half[AW-1:0];
                bank_wdata[k] = 8'd0;
            end
        end
    end

    // Mark written entries; unmarked entries read as zero.
    always_comb begin
        n_vld = r_vld;
        if (main_ok) begin
            n_vld[main_addr[VW-1:0]] = 1'b1;
        end
        if (term_ok) begin
            n_vld[term_addr[VW-1:0]] = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Read side
    // ------------------------------------------------------------------
    logic       rd_ok;
    logic [6:0] rd_half;
    logic [7:0] bank_rdata [2];
    logic [7:0] s1_rd_byte;

    assign rd_ok   = in_fire && (in_func == FN_READ) && (in_idx <= BUF_LAST8);
    assign rd_half = in_idx[7:1];

    for (genvar g = 0; g < 2; g++) begin : g_bank
        sbfr_ram #(
            .WIDTH (8),
            .DEPTH (HALF)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (bank_we[g]),
            .i_waddr (bank_waddr[g]),
            .i_wdata (bank_wdata[g]),
            .i_re    (in_fire),
            .i_raddr (rd_half[AW-1:0]),
            .o_rdata (bank_rdata[g])
        );
    end

    assign s1_rd_byte = r_s1_rd ? (r_s1_bank ? bank_rdata[1] : bank_rdata[0]) : 8'd0;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_wp          <= 8'd0;
            r_id          <= 8'd0;
            r_size        <= 8'd0;
            r_phase       <= PH_SKIP;
            r_neg         <= 1'b0;
            r_after_comma <= 1'b0;
            r_len         <= 8'd0;
            r_kind        <= KIND_NONE;
            r_vld         <= '0;
            r_s1_vld      <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_wp          <= n_wp;
            r_id          <= n_id;
            r_size        <= n_size;
            r_phase       <= n_phase;
            r_neg         <= n_neg;
            r_after_comma <= n_after_comma;
            r_len         <= n_len;
            r_kind        <= n_kind;
            r_vld         <= n_vld;
            if (in_fire) begin
                r_s1_vld <= 1'b1;
            end else if (s1_move) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_move) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload: capture status at acceptance, merge read data on advance.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_rd           <= rd_ok && r_vld[in_idx[VW-1:0]];
            r_s1_bank         <= in_idx[0];
            r_s1_res.state    <= n_state;
            r_s1_res.dropped  <= dropped;
            r_s1_res.length   <= n_len;
            r_s1_res.size     <= n_size;
            r_s1_res.id       <= n_id;
            r_s1_res.kind     <= n_kind;
            r_s1_res.ready    <= (n_state == ST_READY);
        end
        if (s1_move) begin
            r_out_data <= {3'b000, r_s1_res.state, r_s1_res.dropped, s1_rd_byte,
                           r_s1_res.length, r_s1_res.size, r_s1_res.id,
                           r_s1_res.ready};
            r_out_user <= r_s1_res.kind;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

### rtl/sbfr_ram.sv
// ----------------------------------------------------------------------------
// sbfr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sbfr_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 128,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
